/* design/blm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blm_pkg
// Shared constants and the voltage scaling table of the battery level monitor.
// ----------------------------------------------------------------------------
package blm_pkg;

    // Number of scaled samples that make up one average
    localparam int AVG_DEPTH = 10;
    localparam int IDX_W     = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int CNT_W     = $clog2(AVG_DEPTH + 1);

    localparam int ADC_W     = 10;
    localparam int CONF_W    = 8;
    localparam int LVL_W     = 2;
    localparam int VOLT_W    = 6;
    localparam int SUM_W     = VOLT_W + IDX_W;
    localparam int PROD_W    = 16;

    // floor(sum / AVG_DEPTH) as (sum * DIV_RECIP) >> DIV_SHIFT, exact for any sum
    // that fits in SUM_W bits
    localparam int DIV_SHIFT = SUM_W + IDX_W;
    localparam int RECIP_W   = SUM_W + 1;
    localparam int MUL_W     = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] DIV_RECIP =
        RECIP_W'(((1 << DIV_SHIFT) + AVG_DEPTH - 1) / AVG_DEPTH);

    // Configuration register indexes
    localparam logic [1:0] CFG_CUT       = 2'd0;
    localparam logic [1:0] CFG_NEAR_FULL = 2'd1;
    localparam logic [1:0] CFG_FULL      = 2'd2;
    localparam logic [1:0] CFG_CONFIRM   = 2'd3;

    // Battery levels
    localparam logic [LVL_W-1:0] LVL_CUT       = 2'd0;
    localparam logic [LVL_W-1:0] LVL_EMPTY     = 2'd1;
    localparam logic [LVL_W-1:0] LVL_NEAR_FULL = 2'd2;
    localparam logic [LVL_W-1:0] LVL_FULL      = 2'd3;

    localparam logic [ADC_W-1:0]  ADC_FULL_SCALE = 10'd1023;
    localparam logic [CONF_W-1:0] REPEAT_MAX     = 8'd255;
    localparam logic [VOLT_W-1:0] AVG_RESET      = 6'd10;

    // floor(u * 824 / 600) for the coarse reading u = 0..33
    function automatic logic [VOLT_W-1:0] volt_scale(input logic [VOLT_W-1:0] u);
        logic [VOLT_W-1:0] v;
        case (u)
            6'd0:  v = 6'd0;
            6'd1:  v = 6'd1;
            6'd2:  v = 6'd2;
            6'd3:  v = 6'd4;
            6'd4:  v = 6'd5;
            6'd5:  v = 6'd6;
            6'd6:  v = 6'd8;
            6'd7:  v = 6'd9;
            6'd8:  v = 6'd10;
            6'd9:  v = 6'd12;
            6'd10: v = 6'd13;
            6'd11: v = 6'd15;
            6'd12: v = 6'd16;
            6'd13: v = 6'd17;
            6'd14: v = 6'd19;
            6'd15: v = 6'd20;
            6'd16: v = 6'd21;
            6'd17: v = 6'd23;
            6'd18: v = 6'd24;
            6'd19: v = 6'd26;
            6'd20: v = 6'd27;
            6'd21: v = 6'd28;
            6'd22: v = 6'd30;
            6'd23: v = 6'd31;
            6'd24: v = 6'd32;
            6'd25: v = 6'd34;
            6'd26: v = 6'd35;
            6'd27: v = 6'd37;
            6'd28: v = 6'd38;
            6'd29: v = 6'd39;
            6'd30: v = 6'd41;
            6'd31: v = 6'd42;
            6'd32: v = 6'd43;
            6'd33: v = 6'd45;
            default: v = 6'd0;
        endcase
        return v;
    endfunction

endpackage

/* design/battery_level_monitor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_level_monitor
// Classifies battery ADC samples into a falling-only latched level and keeps
// a running average of the scaled voltage over a small sample store.
// ----------------------------------------------------------------------------
// One transaction at a time. A reset command passes the calc and emit states
// and then the output register; a sample that does not close an average
// also passes the write state; the sample that fills the store also passes
// the sum state, reading the store back one entry a cycle through its single
// read port, and the divide state, one multiply by the reciprocal of the
// depth. A new transaction is taken while the previous result still waits at
// the output. Thresholds and the confirm count may only be written while the
// block is idle; the configuration port is always ready.

module battery_level_monitor
    import blm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [ADC_W-1:0]  i_cfg_data,

    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_cmd,
    input  logic [ADC_W-1:0]  i_sample,

    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [LVL_W-1:0]  o_level,
    output logic [VOLT_W-1:0] o_avg_voltage,
    output logic              o_avg_updated
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CALC  = 3'd1;
    localparam logic [2:0] ST_WRITE = 3'd2;
    localparam logic [2:0] ST_SUM   = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    // Configuration
    logic [ADC_W-1:0]  r_cut_thr;
    logic [ADC_W-1:0]  r_near_thr;
    logic [ADC_W-1:0]  r_full_thr;
    logic [CONF_W-1:0] r_confirm;

    // Control and scalar state
    logic [2:0]        r_state;
    logic              r_cmd;
    logic [ADC_W-1:0]  r_sample;
    logic [LVL_W-1:0]  r_latched;
    logic [LVL_W-1:0]  r_last_class;
    logic [CONF_W-1:0] r_repeat;
    logic [IDX_W-1:0]  r_index;
    logic [VOLT_W-1:0] r_avg;
    logic              r_updated;
    logic [VOLT_W-1:0] r_coarse;
    logic [CNT_W-1:0]  r_cnt;
    logic [SUM_W-1:0]  r_sum;

    // Sample store
    logic [VOLT_W-1:0] r_store [AVG_DEPTH];
    logic [VOLT_W-1:0] r_rd_data;
    logic              mem_we;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_rd_addr;

    // Datapath
    logic [LVL_W-1:0]  cls;
    logic [CONF_W-1:0] n_repeat;
    logic [PROD_W-1:0] prod;
    logic [VOLT_W-1:0] q0;
    logic [ADC_W:0]    rmd;
    logic [VOLT_W-1:0] n_coarse;
    logic [MUL_W-1:0]  avg_prod;
    logic              out_free;
    logic              in_accept;
    logic              last_slot;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_free    = !o_out_valid || !i_out_stall;
    assign last_slot   = (r_index == IDX_W'(AVG_DEPTH - 1));

    // Classes are tested in order, so unordered thresholds still give one class
    always_comb begin
        if (r_sample < r_cut_thr) begin
            cls = LVL_CUT;
        end else if (r_sample < r_near_thr) begin
            cls = LVL_EMPTY;
        end else if (r_sample < r_full_thr) begin
            cls = LVL_NEAR_FULL;
        end else begin
            cls = LVL_FULL;
        end
    end

    assign n_repeat = (r_repeat == REPEAT_MAX) ? r_repeat : r_repeat + 8'd1;

    // floor(33 * s / 1023): estimate by a shift, then one correction step
    assign prod = {1'b0, r_sample, 5'd0} + PROD_W'(r_sample);
    assign q0   = prod[PROD_W-1:ADC_W];
    assign rmd  = {1'b0, prod[ADC_W-1:0]} + (ADC_W + 1)'(q0);
    assign n_coarse = (rmd >= {1'b0, ADC_FULL_SCALE}) ? q0 + 6'd1 : q0;

    // Divide the store sum by its depth through the reciprocal
    assign avg_prod = MUL_W'(r_sum) * MUL_W'(DIV_RECIP);

    assign mem_we      = (r_state == ST_WRITE);
    assign mem_re      = (r_state == ST_SUM) && (r_cnt < CNT_W'(AVG_DEPTH));
    assign mem_rd_addr = r_cnt[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[r_index] <= volt_scale(r_coarse);
        end
        if (mem_re) begin
            r_rd_data <= r_store[mem_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cut_thr  <= 10'd790;
            r_near_thr <= 10'd806;
            r_full_thr <= 10'd940;
            r_confirm  <= 8'd2;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_CUT:       r_cut_thr  <= i_cfg_data;
                CFG_NEAR_FULL: r_near_thr <= i_cfg_data;
                CFG_FULL:      r_full_thr <= i_cfg_data;
                CFG_CONFIRM:   r_confirm  <= i_cfg_data[CONF_W-1:0];
                default: ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd    <= i_cmd;
            r_sample <= i_sample;
        end
        if (r_state == ST_CALC) begin
            r_coarse <= n_coarse;
        end
        if (r_state == ST_WRITE) begin
            r_sum <= '0;
        end else if (r_state == ST_SUM && r_cnt != '0) begin
            r_sum <= r_sum + SUM_W'(r_rd_data);
        end
        if (r_state == ST_EMIT && out_free) begin
            o_level       <= r_latched;
            o_avg_voltage <= r_avg;
            o_avg_updated <= r_updated;
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_latched    <= LVL_FULL;
            r_last_class <= LVL_CUT;
            r_repeat     <= '0;
            r_index      <= '0;
            r_avg        <= AVG_RESET;
            r_updated    <= 1'b0;
            r_cnt        <= '0;
            o_out_valid  <= 1'b0;
        end else begin
            if (r_state == ST_EMIT && out_free) begin
                o_out_valid <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_state <= ST_CALC;
                    end
                end
                ST_CALC: begin
                    r_updated <= 1'b0;
                    if (r_cmd) begin
                        r_latched <= LVL_FULL;
                        r_state   <= ST_EMIT;
                    end else begin
                        if (cls != r_last_class) begin
                            r_repeat     <= '0;
                            r_last_class <= cls;
                        end else begin
                            r_repeat <= n_repeat;
                            if (n_repeat > r_confirm && r_latched > cls) begin
                                r_latched <= cls;
                            end
                        end
                        r_state <= ST_WRITE;
                    end
                end
                ST_WRITE: begin
                    r_cnt <= '0;
                    if (last_slot) begin
                        r_index <= '0;
                        r_state <= ST_SUM;
                    end else begin
                        r_index <= r_index + IDX_W'(1);
                        r_state <= ST_EMIT;
                    end
                end
                ST_SUM: begin
                    // read data is registered and arrives in the cycle after its address
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(AVG_DEPTH)) begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_avg     <= avg_prod[DIV_SHIFT +: VOLT_W];
                    r_updated <= 1'b1;
                    r_state   <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

/* tb/battery_level_monitor_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_level_monitor_tb
// Self-checking bench for the battery level monitor. Directed runs cover the
// falling-only latch, the reset command, unordered thresholds and repeat
// counter saturation. Randomised sample runs follow under three idle
// patterns, then one long output hold-off. Each result is checked against a
// behavioural prediction of level, average and update flag.
// ----------------------------------------------------------------------------
module battery_level_monitor_tb;
    import blm_pkg::*;

    localparam int RESET_CYCLES = 5;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 10;
    localparam int PHASE_ITEMS  = 30;

    // coarse volts = floor(floor(SCALE_MUL * s / full scale) * SCALE_NUM / SCALE_DEN)
    localparam int SCALE_MUL = 33;
    localparam int SCALE_NUM = 824;
    localparam int SCALE_DEN = 600;

    typedef struct packed {
        logic [LVL_W-1:0]  level;
        logic [VOLT_W-1:0] avg;
        logic              updated;
    } t_reading;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [1:0]        cfg_index = CFG_CUT;
    logic [ADC_W-1:0]  cfg_data  = '0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    logic              in_cmd    = 1'b0;
    logic [ADC_W-1:0]  in_sample = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [LVL_W-1:0]  out_level;
    logic [VOLT_W-1:0] out_avg;
    logic              out_updated;

    int send_idle_pct = 12;
    int recv_idle_pct = 75;
    int hold_trig     = 0;
    int hold_ack      = 0;
    int hold_left     = 0;
    int mismatches    = 0;
    int readings_seen = 0;
    int cycle_cnt     = 0;

    // Predicted monitor state
    logic [ADC_W-1:0]  cut_thr;
    logic [ADC_W-1:0]  near_thr;
    logic [ADC_W-1:0]  full_thr;
    logic [CONF_W-1:0] confirm;
    logic [LVL_W-1:0]  latch_lvl;
    logic [LVL_W-1:0]  prev_cls;
    logic [CONF_W-1:0] run_cnt;
    logic [VOLT_W-1:0] volt_hist [AVG_DEPTH];
    int                hist_pos;
    logic [VOLT_W-1:0] avg_volt;

    t_reading expected_readings[$];

    battery_level_monitor DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_cmd         (in_cmd),
        .i_sample      (in_sample),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_level       (out_level),
        .o_avg_voltage (out_avg),
        .o_avg_updated (out_updated)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("battery_level_monitor_tb NOT OK");
            $finish;
        end
    end

    // Receiver: a requested hold-off wins over random stalls
    always @(posedge clk) begin
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_trig != hold_ack) begin
            hold_ack  <= hold_trig;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk) begin : check_readings
        t_reading want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_readings.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected result: level %0d avg %0d upd %0d",
                             out_level, out_avg, out_updated);
                mismatches++;
            end else begin
                want = expected_readings.pop_front();
                if (out_level !== want.level || out_avg !== want.avg ||
                        out_updated !== want.updated) begin
                    if (mismatches < MAX_REPORTS)
                        $display({"reading %0d: expected level %0d avg %0d upd %0d, ",
                                  "got level %0d avg %0d upd %0d"},
                                 readings_seen, want.level, want.avg, want.updated,
                                 out_level, out_avg, out_updated);
                    mismatches++;
                end
            end
            readings_seen++;
        end
    end

    task automatic predict_reading(input logic cmd, input logic [ADC_W-1:0] smp);
        logic [LVL_W-1:0] cls;
        int coarse;
        int sum;
        t_reading r;
        r.updated = 1'b0;
        if (cmd) begin
            latch_lvl = LVL_FULL;
        end else begin
            if (smp < cut_thr)
                cls = LVL_CUT;
            else if (smp < near_thr)
                cls = LVL_EMPTY;
            else if (smp < full_thr)
                cls = LVL_NEAR_FULL;
            else
                cls = LVL_FULL;
            if (cls != prev_cls) begin
                run_cnt  = '0;
                prev_cls = cls;
            end else begin
                // saturate, never wrap
                if (run_cnt != REPEAT_MAX)
                    run_cnt = run_cnt + 8'd1;
                if (run_cnt > confirm && latch_lvl > cls)
                    latch_lvl = cls;
            end
            coarse = (SCALE_MUL * int'(smp)) / int'(ADC_FULL_SCALE);
            volt_hist[hist_pos] = VOLT_W'((coarse * SCALE_NUM) / SCALE_DEN);
            hist_pos++;
            if (hist_pos == AVG_DEPTH) begin
                sum = 0;
                foreach (volt_hist[k])
                    sum += int'(volt_hist[k]);
                avg_volt  = VOLT_W'(sum / AVG_DEPTH);
                hist_pos  = 0;
                r.updated = 1'b1;
            end
        end
        r.level = latch_lvl;
        r.avg   = avg_volt;
        expected_readings.push_back(r);
    endtask

    task automatic reset_monitor();
        cut_thr   = 10'd790;
        near_thr  = 10'd806;
        full_thr  = 10'd940;
        confirm   = 8'd2;
        latch_lvl = LVL_FULL;
        prev_cls  = LVL_CUT;
        run_cnt   = '0;
        hist_pos  = 0;
        avg_volt  = AVG_RESET;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
    endtask

    // Leaves valid high after the transaction; a drain, or an idle gap in the next call, lowers it
    task automatic send_item(input logic cmd, input logic [ADC_W-1:0] smp);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_cmd    <= cmd;
        in_sample <= smp;
        do @(posedge clk); while (in_stall);
        predict_reading(cmd, smp);
    endtask

    task automatic drain_readings();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_readings.size() != 0);
    endtask

    task automatic write_config(input logic [ADC_W-1:0] cut_v, input logic [ADC_W-1:0] near_v,
                                input logic [ADC_W-1:0] full_v, input logic [CONF_W-1:0] conf_v);
        logic [ADC_W-1:0] vals [4];
        logic [1:0]       idx [4];
        vals = '{cut_v, near_v, full_v, ADC_W'(conf_v)};
        idx  = '{CFG_CUT, CFG_NEAR_FULL, CFG_FULL, CFG_CONFIRM};
        for (int k = 0; k < 4; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= vals[k];
            do @(posedge clk); while (!cfg_ready);
            case (idx[k])
                CFG_CUT:       cut_thr  = vals[k];
                CFG_NEAR_FULL: near_thr = vals[k];
                CFG_FULL:      full_thr = vals[k];
                CFG_CONFIRM:   confirm  = vals[k][CONF_W-1:0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic write_random_config();
        logic [ADC_W-1:0]  t0, t1, t2, tmp;
        logic [CONF_W-1:0] c;
        t0 = ADC_W'($urandom_range(1023));
        t1 = ADC_W'($urandom_range(1023));
        t2 = ADC_W'($urandom_range(1023));
        case ($urandom_range(3))
            0: begin
                // ordered thresholds
                if (t0 > t1) begin tmp = t0; t0 = t1; t1 = tmp; end
                if (t1 > t2) begin tmp = t1; t1 = t2; t2 = tmp; end
                if (t0 > t1) begin tmp = t0; t0 = t1; t1 = tmp; end
            end
            1: ;
            2: begin
                t0 = $urandom_range(1) ? ADC_FULL_SCALE : '0;
                t1 = $urandom_range(1) ? ADC_FULL_SCALE : '0;
                t2 = $urandom_range(1) ? ADC_FULL_SCALE : '0;
            end
            default: begin
                t0 = 10'd790;
                t1 = 10'd806;
                t2 = 10'd940;
            end
        endcase
        c = ($urandom_range(9) == 0) ? 8'd254 : CONF_W'($urandom_range(4));
        write_config(t0, t1, t2, c);
    endtask

    // Runs of near-identical samples so classes repeat past the confirm count
    task automatic send_sample_runs(input int n_items, input int run_max);
        int left;
        int run_len;
        int roll;
        logic [ADC_W-1:0] base;
        left = n_items;
        while (left > 0) begin
            base    = ADC_W'($urandom_range(1023));
            run_len = $urandom_range(run_max, 1);
            for (int k = 0; k < run_len && left > 0; k++) begin
                roll = $urandom_range(99);
                if (roll < 8)
                    send_item(1'b1, ADC_W'($urandom));
                else if (roll < 20)
                    send_item(1'b0, ADC_W'($urandom_range(1023)));
                else if (roll < 30)
                    send_item(1'b0, base ^ ADC_W'($urandom_range(3)));
                else
                    send_item(1'b0, base);
                left--;
            end
        end
    endtask

    task automatic test_level_latch();
        repeat (3) send_item(1'b0, 10'd0);
        send_item(1'b1, 10'h3FF);
        repeat (2) send_item(1'b0, 10'd1023);
        send_item(1'b0, 10'd789);
        send_item(1'b0, 10'd790);
        repeat (4) send_item(1'b0, 10'd805);
        send_item(1'b0, 10'd806);
        // level must not rise back to near full
        repeat (3) send_item(1'b0, 10'd939);
        send_item(1'b0, 10'd940);
        send_item(1'b1, 10'd0);
        send_item(1'b0, 10'd940);
        drain_readings();
    endtask

    task automatic test_unordered_thresholds();
        write_config(10'd512, 10'd0, 10'd1023, 8'd0);
        send_item(1'b0, 10'd1023);
        send_item(1'b0, 10'd511);
        send_item(1'b0, 10'd512);
        send_item(1'b0, 10'd600);
        send_item(1'b0, 10'd0);
        send_item(1'b0, 10'd5);
        send_item(1'b1, 10'd512);
        drain_readings();
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n_items);
        int run_max;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int p = 0; p < n_items / PHASE_ITEMS; p++) begin
            write_random_config();
            run_max = (confirm < 8) ? int'(confirm) + 4 : 12;
            send_sample_runs(PHASE_ITEMS, run_max);
            drain_readings();
        end
    endtask

    // Confirm count of 254 is only exceeded once the counter sits at its limit
    task automatic test_counter_saturation();
        write_config(10'd1023, 10'd1023, 10'd0, 8'd254);
        send_item(1'b0, 10'd1023);
        for (int k = 0; k < 260; k++) begin
            if (k == 100)
                send_item(1'b1, ADC_W'($urandom));
            send_item(1'b0, ADC_W'($urandom_range(1022)));
        end
        send_item(1'b1, ADC_W'($urandom));
        repeat (3) send_item(1'b0, ADC_W'($urandom_range(1022)));
        drain_readings();
    endtask

    task automatic test_output_hold_off();
        write_config(10'd0, 10'd512, 10'd1023, 8'd1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_trig <= hold_trig + 1;
        // keep offering while the output is held so the input stalls
        for (int k = 0; k < 20; k++)
            send_item($urandom_range(9) == 0, ADC_W'($urandom_range(1023)));
        drain_readings();
    endtask

    initial begin
        reset_monitor();
        test_level_latch();
        test_unordered_thresholds();
        test_random_traffic(12, 75, 90);
        test_random_traffic(75, 12, 90);
        test_random_traffic(0, 0, 90);
        test_counter_saturation();
        test_output_hold_off();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_readings.size() == 0)
            $display("battery_level_monitor_tb OK");
        else
            $display("battery_level_monitor_tb NOT OK");
        $finish;
    end

endmodule
